[design/cst_pkg.sv]
// Shared types and constants for the CSV record tokenizer.
// No dependencies; used by cst_classify and csv_record_tokenizer.
package cst_pkg;

    // Character codes
    localparam logic [7:0] QUOTE_CHAR = 8'd34;
    localparam logic [7:0] LF_CHAR    = 8'd10;
    localparam logic [7:0] CR_CHAR    = 8'd13;
    localparam logic [7:0] TAB_CHAR   = 8'd9;
    localparam logic [7:0] VT_CHAR    = 8'd11;
    localparam logic [7:0] FF_CHAR    = 8'd12;
    localparam logic [7:0] SPACE_CHAR = 8'd32;

    // Register reset values and register indexes
    localparam logic [7:0] DELIMITER_RESET = 8'd44;
    localparam logic       TRIM_RESET      = 1'b1;
    localparam logic       REG_DELIMITER   = 1'b0;
    localparam logic       REG_TRIM        = 1'b1;

    // Sizing
    localparam int MAX_HELD_SPACES = 63;
    localparam int MAX_COLUMNS     = 1024;
    localparam int COLUMN_W        = 10;
    localparam logic [COLUMN_W-1:0] COLUMN_CAP =
        (MAX_COLUMNS - 1 > 1023) ? COLUMN_W'(1023) : COLUMN_W'(MAX_COLUMNS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_FINAL
    } state_t;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_CONTENT,
        ACT_FIELD_END,
        ACT_RECORD_END
    } act_t;

    typedef struct packed {
        logic in_quoted;
        logic quote_lookahead;
        logic field_has_content;
        logic record_started;
    } flags_t;

    typedef struct packed {
        act_t   act;
        flags_t flags;
        logic   hold_push;
        logic   col_inc;
        logic   end_rec;
    } decision_t;

endpackage

[design/cst_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 63,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[design/cst_classify.sv]
// Per-byte decision logic: quote lookahead, delimiter, trim and record rules.
// Depends on cst_pkg for flag and decision types and character codes.
module cst_classify (
    input  logic                kind,
    input  logic [7:0]          data_byte,
    input  logic [7:0]          delimiter,
    input  logic                trim,
    input  logic                hold_full,
    input  cst_pkg::flags_t     flags_i,
    output cst_pkg::decision_t  dec_o
);

    logic ws;
    logic inq;
    logic quote_pair;

    assign ws = (data_byte == cst_pkg::TAB_CHAR) || (data_byte == cst_pkg::VT_CHAR) ||
                (data_byte == cst_pkg::FF_CHAR)  || (data_byte == cst_pkg::SPACE_CHAR);
    assign quote_pair = flags_i.quote_lookahead && (data_byte == cst_pkg::QUOTE_CHAR);
    // pending lookahead quote followed by anything else closes the quoted run
    assign inq = flags_i.in_quoted && !flags_i.quote_lookahead;

    always_comb begin
        dec_o           = '0;
        dec_o.act       = cst_pkg::ACT_NONE;
        dec_o.flags     = flags_i;
        if (kind || data_byte == cst_pkg::LF_CHAR) begin
            dec_o.end_rec = 1'b1;
            dec_o.flags   = '0;
            if (flags_i.record_started) begin
                dec_o.act = cst_pkg::ACT_RECORD_END;
            end
        end else if (data_byte != cst_pkg::CR_CHAR) begin
            dec_o.flags.quote_lookahead = 1'b0;
            dec_o.flags.in_quoted       = inq;
            if (quote_pair) begin
                // doubled quote: literal quote, stay quoted
                dec_o.flags.in_quoted         = 1'b1;
                dec_o.flags.field_has_content = 1'b1;
                dec_o.act                     = cst_pkg::ACT_CONTENT;
            end else if (data_byte == cst_pkg::QUOTE_CHAR) begin
                dec_o.flags.record_started = 1'b1;
                if (inq) begin
                    dec_o.flags.quote_lookahead = 1'b1;
                end else begin
                    dec_o.flags.in_quoted = 1'b1;
                end
            end else if (!inq && data_byte == delimiter) begin
                if (!(trim && ws && !flags_i.record_started)) begin
                    dec_o.flags.record_started    = 1'b1;
                    dec_o.flags.field_has_content = 1'b0;
                    dec_o.act                     = cst_pkg::ACT_FIELD_END;
                    dec_o.col_inc                 = 1'b1;
                end
            end else if (trim && ws) begin
                // hold inner whitespace, drop leading and overflow bytes
                if (flags_i.record_started && flags_i.field_has_content && !hold_full) begin
                    dec_o.hold_push = 1'b1;
                end
            end else begin
                dec_o.flags.record_started    = 1'b1;
                dec_o.flags.field_has_content = 1'b1;
                dec_o.act                     = cst_pkg::ACT_CONTENT;
            end
        end
    end

endmodule

[design/csv_record_tokenizer.sv]
// CSV record tokenizer: splits a byte stream into field bytes and field/record marks.
// Results are registered in the output register. Input takes one item per cycle while
// the result slot is free; a content byte that releases held whitespace blocks input
// until the held bytes, read from the hold RAM, and then the byte itself are sent.
// Reset (aresetn, synchronous): control flags, column, hold count and output valid clear;
// delimiter resets to 44, trim to 1. The hold RAM is not cleared; its fill count guards it.
module csv_record_tokenizer #(
    parameter int MAX_HELD_SPACES = cst_pkg::MAX_HELD_SPACES
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [7:0]  s_data_byte,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_field_end,
    output logic        m_record_end,
    output logic [cst_pkg::COLUMN_W-1:0] m_column,
    output logic        m_last
);

    localparam int AW = (MAX_HELD_SPACES > 1) ? $clog2(MAX_HELD_SPACES) : 1;
    localparam int CW = $clog2(MAX_HELD_SPACES + 1);
    localparam logic [CW-1:0] HOLD_MAX = CW'(MAX_HELD_SPACES);

    // configuration
    logic [7:0] delimiter_reg;
    logic       trim_reg;
    logic       cfg_write;

    // control state
    cst_pkg::state_t  state_reg, state_next;
    cst_pkg::flags_t  flags_reg, flags_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [AW-1:0]    idx_reg, idx_next;
    logic [cst_pkg::COLUMN_W-1:0] col_reg, col_next;
    logic [7:0]       pend_reg, pend_next;

    // output register
    logic             m_valid_reg, m_valid_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic             field_end_reg, field_end_next;
    logic             record_end_reg, record_end_next;
    logic [cst_pkg::COLUMN_W-1:0] column_reg, column_next;
    logic             last_reg, last_next;

    logic               accept;
    logic               slot_free;
    logic               load;
    logic               drain_last;
    logic [7:0]         hold_rdata;
    cst_pkg::decision_t dec;

    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == cst_pkg::REG_TRIM) ? {31'b0, trim_reg}
                                                       : {24'b0, delimiter_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delimiter_reg <= cst_pkg::DELIMITER_RESET;
            trim_reg      <= cst_pkg::TRIM_RESET;
        end else if (cfg_write) begin
            if (paddr[2] == cst_pkg::REG_DELIMITER) begin
                delimiter_reg <= pwdata[7:0];
            end else begin
                trim_reg <= pwdata[0];
            end
        end
    end

    assign slot_free  = !m_valid_reg || m_ready;
    assign s_ready    = (state_reg == cst_pkg::ST_IDLE) && slot_free;
    assign accept     = s_valid && s_ready;
    assign drain_last = (CW'(idx_reg) + CW'(1)) == count_reg;

    cst_classify u_classify (
        .kind      (s_kind),
        .data_byte (s_data_byte),
        .delimiter (delimiter_reg),
        .trim      (trim_reg),
        .hold_full (count_reg == HOLD_MAX),
        .flags_i   (flags_reg),
        .dec_o     (dec)
    );

    cst_ram #(
        .WIDTH (8),
        .DEPTH (MAX_HELD_SPACES)
    ) u_hold_ram (
        .aclk  (aclk),
        .we    (accept && dec.hold_push),
        .waddr (AW'(count_reg)),
        .wdata (s_data_byte),
        .raddr (idx_next),
        .rdata (hold_rdata)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            cst_pkg::ST_IDLE: begin
                if (accept && dec.act == cst_pkg::ACT_CONTENT && count_reg != '0) begin
                    state_next = cst_pkg::ST_DRAIN;
                end
            end
            cst_pkg::ST_DRAIN: begin
                if (slot_free && drain_last) begin
                    state_next = cst_pkg::ST_FINAL;
                end
            end
            cst_pkg::ST_FINAL: begin
                if (slot_free) begin
                    state_next = cst_pkg::ST_IDLE;
                end
            end
            default: state_next = cst_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        flags_next      = flags_reg;
        count_next      = count_reg;
        idx_next        = '0;
        col_next        = col_reg;
        pend_next       = pend_reg;
        load            = 1'b0;
        out_byte_next   = out_byte_reg;
        field_end_next  = field_end_reg;
        record_end_next = record_end_reg;
        column_next     = column_reg;
        last_next       = last_reg;
        case (state_reg)
            cst_pkg::ST_IDLE: begin
                if (accept) begin
                    flags_next = dec.flags;
                    pend_next  = s_data_byte;
                    if (dec.end_rec) begin
                        count_next = '0;
                        col_next   = '0;
                    end else if (dec.act == cst_pkg::ACT_FIELD_END) begin
                        count_next = '0;
                        if (col_reg < cst_pkg::COLUMN_CAP) begin
                            col_next = col_reg + cst_pkg::COLUMN_W'(1);
                        end
                    end else if (dec.hold_push) begin
                        count_next = count_reg + CW'(1);
                    end
                    out_byte_next   = s_data_byte;
                    field_end_next  = 1'b0;
                    record_end_next = 1'b0;
                    column_next     = col_reg;
                    last_next       = 1'b1;
                    case (dec.act)
                        cst_pkg::ACT_CONTENT: begin
                            load = (count_reg == '0);
                        end
                        cst_pkg::ACT_FIELD_END: begin
                            load           = 1'b1;
                            out_byte_next  = '0;
                            field_end_next = 1'b1;
                        end
                        cst_pkg::ACT_RECORD_END: begin
                            load            = 1'b1;
                            out_byte_next   = '0;
                            field_end_next  = 1'b1;
                            record_end_next = 1'b1;
                        end
                        default: load = 1'b0;
                    endcase
                end
            end
            cst_pkg::ST_DRAIN: begin
                idx_next = idx_reg;
                if (slot_free) begin
                    load            = 1'b1;
                    out_byte_next   = hold_rdata;
                    field_end_next  = 1'b0;
                    record_end_next = 1'b0;
                    column_next     = col_reg;
                    last_next       = 1'b0;
                    // advance the read address unless this was the last held byte
                    if (!drain_last) begin
                        idx_next = idx_reg + AW'(1);
                    end
                end
            end
            cst_pkg::ST_FINAL: begin
                if (slot_free) begin
                    load            = 1'b1;
                    out_byte_next   = pend_reg;
                    field_end_next  = 1'b0;
                    record_end_next = 1'b0;
                    column_next     = col_reg;
                    last_next       = 1'b1;
                    count_next      = '0;
                end
            end
            default: idx_next = '0;
        endcase
        m_valid_next = load || (m_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= cst_pkg::ST_IDLE;
            flags_reg   <= '0;
            count_reg   <= '0;
            idx_reg     <= '0;
            col_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            flags_reg   <= flags_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            col_reg     <= col_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_reg <= pend_next;
        if (load) begin
            out_byte_reg   <= out_byte_next;
            field_end_reg  <= field_end_next;
            record_end_reg <= record_end_next;
            column_reg     <= column_next;
            last_reg       <= last_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_byte   = out_byte_reg;
    assign m_field_end  = field_end_reg;
    assign m_record_end = record_end_reg;
    assign m_column     = column_reg;
    assign m_last       = last_reg;

endmodule

[dv/tb_top.sv]
// Self-checking testbench for csv_record_tokenizer: drives bytes and flushes, predicts
// the field bytes and field/record marks, and checks every result in order.
// Depends on cst_pkg (character codes, register indexes, sizing) and the RTL top level.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD     = 6;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 4;
    localparam int PHASE_ITEMS     = 14;
    localparam int WIDE_FIELDS     = 24;
    localparam int MAX_STEP_TOKENS = 64;
    localparam logic KIND_DATA  = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    typedef struct packed {
        logic [7:0]                   ch;
        logic                         fend;
        logic                         rend;
        logic [cst_pkg::COLUMN_W-1:0] col;
        logic                         lst;
    } token_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;
    logic                s_valid;
    logic                s_ready;
    logic                s_kind;
    logic [7:0]          s_data_byte;
    logic                m_valid;
    logic                m_ready;
    logic [7:0]          m_out_byte;
    logic                m_field_end;
    logic                m_record_end;
    logic [cst_pkg::COLUMN_W-1:0] m_column;
    logic                m_last;

    // tokenizer state mirrored by the predictor
    logic [7:0]          cfg_delim;
    logic                cfg_trim;
    logic                st_quoted;
    logic                st_quote_pending;
    logic                st_has_text;
    logic                st_rec_open;
    int                  hold_cnt;
    logic [7:0]          hold_buf [cst_pkg::MAX_HELD_SPACES];
    logic [cst_pkg::COLUMN_W-1:0] col_idx;

    token_t step_tokens[$];
    token_t expected_tokens[$];
    int     mismatch_count = 0;
    int     items_sent = 0;
    int     burst_left = 0;
    bit     hold_off_req = 1'b0;

    always #HALF_PERIOD aclk = ~aclk;

    csv_record_tokenizer u_top (
        .aclk, .aresetn,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .s_valid, .s_ready, .s_kind, .s_data_byte,
        .m_valid, .m_ready, .m_out_byte, .m_field_end, .m_record_end, .m_column, .m_last
    );

    // ---------------- predictor ----------------

    function automatic logic is_blank(logic [7:0] c);
        return c == cst_pkg::TAB_CHAR || c == cst_pkg::VT_CHAR ||
               c == cst_pkg::FF_CHAR || c == cst_pkg::SPACE_CHAR;
    endfunction

    function automatic void push_token(logic [7:0] c, logic fe, logic re);
        token_t t;
        t.ch   = c;
        t.fend = fe;
        t.rend = re;
        t.col  = col_idx;
        t.lst  = 1'b0;
        if (step_tokens.size() < MAX_STEP_TOKENS) step_tokens.push_back(t);
    endfunction

    // release held whitespace ahead of a content byte
    function automatic void emit_text(logic [7:0] c);
        for (int i = 0; i < hold_cnt; i++) push_token(hold_buf[i], 1'b0, 1'b0);
        hold_cnt = 0;
        push_token(c, 1'b0, 1'b0);
        st_has_text = 1'b1;
    endfunction

    function automatic void close_record();
        if (st_rec_open) push_token(8'd0, 1'b1, 1'b1);
        st_quoted        = 1'b0;
        st_quote_pending = 1'b0;
        st_has_text      = 1'b0;
        st_rec_open      = 1'b0;
        hold_cnt         = 0;
        col_idx          = '0;
    endfunction

    function automatic void take_char(logic [7:0] c);
        if (st_quote_pending) begin
            st_quote_pending = 1'b0;
            if (c == cst_pkg::QUOTE_CHAR) begin
                emit_text(c);
                return;
            end
            st_quoted = 1'b0;
        end
        if (c == cst_pkg::QUOTE_CHAR) begin
            st_rec_open = 1'b1;
            if (st_quoted) st_quote_pending = 1'b1;
            else st_quoted = 1'b1;
            return;
        end
        if (!st_quoted && c == cfg_delim) begin
            if (cfg_trim && is_blank(c) && !st_rec_open) return;
            st_rec_open = 1'b1;
            push_token(8'd0, 1'b1, 1'b0);
            hold_cnt    = 0;
            st_has_text = 1'b0;
            if (col_idx < cst_pkg::COLUMN_CAP) col_idx++;
            return;
        end
        if (cfg_trim && is_blank(c)) begin
            if (!st_rec_open || !st_has_text) return;
            if (hold_cnt < cst_pkg::MAX_HELD_SPACES) begin
                hold_buf[hold_cnt] = c;
                hold_cnt++;
            end
            return;
        end
        st_rec_open = 1'b1;
        emit_text(c);
    endfunction

    function automatic void predict_tokens(logic k, logic [7:0] c);
        token_t t;
        step_tokens.delete();
        if (k == KIND_FLUSH || c == cst_pkg::LF_CHAR) close_record();
        else if (c != cst_pkg::CR_CHAR) take_char(c);
        while (step_tokens.size() > 0) begin
            t = step_tokens.pop_front();
            t.lst = (step_tokens.size() == 0);
            expected_tokens.push_back(t);
        end
    endfunction

    // ---------------- checking ----------------

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (act_v !== exp_v) begin
            mismatch_count++;
            $display("%0t ns: %s expected %0h actual %0h", $time, name, exp_v, act_v);
        end
    endfunction

    always @(posedge aclk) begin
        token_t t;
        if (aresetn && m_valid && m_ready) begin
            if (expected_tokens.size() == 0) begin
                mismatch_count++;
                $display("%0t ns: no result expected, actual %0h/%0b/%0b/%0d",
                         $time, m_out_byte, m_field_end, m_record_end, m_column);
            end else begin
                t = expected_tokens.pop_front();
                check_field("out_byte", 32'(t.ch), 32'(m_out_byte));
                check_field("field_end", 32'(t.fend), 32'(m_field_end));
                check_field("record_end", 32'(t.rend), 32'(m_record_end));
                check_field("column", 32'(t.col), 32'(m_column));
                check_field("last", 32'(t.lst), 32'(m_last));
            end
        end
    end

    // end the run when neither channel moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // receiver: stall pattern changes every so often; a requested hold-off stalls long
    initial begin : rx_stalls
        int rx_mode;
        int rx_left;
        int rx_tick;
        rx_mode = 0;
        rx_left = 0;
        rx_tick = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                hold_off_req = 1'b0;
            end
            if (rx_left == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(20, 200);
            end
            rx_left--;
            rx_tick++;
            case (rx_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 3) != 0);
                2: m_ready <= (rx_tick % 5 < 3);
                default: m_ready <= ($urandom_range(0, 1) == 1);
            endcase
        end
    end

    // ---------------- drivers ----------------

    task automatic apply_reset();
        cfg_delim = cst_pkg::DELIMITER_RESET;
        cfg_trim  = cst_pkg::TRIM_RESET;
        close_record();
        aresetn <= 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
    endtask

    task automatic send_item(logic k, logic [7:0] c);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid     <= 1'b1;
        s_kind      <= k;
        s_data_byte <= c;
        do @(posedge aclk); while (!s_ready);
        predict_tokens(k, c);
        items_sent++;
    endtask

    task automatic send_char(logic [7:0] c);
        send_item(KIND_DATA, c);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i]);
    endtask

    // drop valid, then wait for every expected result and a further drain period
    task automatic settle();
        s_valid <= 1'b0;
        burst_left = 0;
        while (expected_tokens.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (idx == cst_pkg::REG_DELIMITER) cfg_delim = value[7:0];
        else cfg_trim = value[0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic read_check(logic idx, logic [31:0] exp_v, logic [31:0] mask);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        check_field(idx == cst_pkg::REG_DELIMITER ? "delimiter_char" : "trim_enable",
                    exp_v & mask, prdata & mask);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_config(logic [7:0] delim, logic trim);
        settle();
        write_reg(cst_pkg::REG_DELIMITER, {24'd0, delim});
        write_reg(cst_pkg::REG_TRIM, {31'd0, trim});
        read_check(cst_pkg::REG_DELIMITER, {24'd0, delim}, 32'hFF);
        read_check(cst_pkg::REG_TRIM, {31'd0, trim}, 32'h1);
    endtask

    // ---------------- stimulus helpers ----------------

    function automatic logic [7:0] blank_char();
        case ($urandom_range(0, 3))
            0: return cst_pkg::TAB_CHAR;
            1: return cst_pkg::VT_CHAR;
            2: return cst_pkg::FF_CHAR;
            default: return cst_pkg::SPACE_CHAR;
        endcase
    endfunction

    function automatic logic [7:0] text_char();
        logic [7:0] c;
        c = 8'($urandom_range(33, 126));
        if (c == cst_pkg::QUOTE_CHAR || c == cfg_delim) c = "x";
        if ($urandom_range(0, 7) == 0) c = blank_char();
        return c;
    endfunction

    task automatic send_blanks(int n);
        for (int i = 0; i < n; i++) send_char(blank_char());
    endtask

    task automatic send_random_record();
        int n_fields;
        int len;
        int ending;
        n_fields = ($urandom_range(0, 15) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 5);
        for (int f = 0; f < n_fields; f++) begin
            if (f > 0) send_char(cfg_delim);
            if ($urandom_range(0, 3) == 0) send_blanks($urandom_range(1, 3));
            len = $urandom_range(1, 8);
            case ($urandom_range(0, 3))
                0: ;  // empty field
                3: begin
                    send_char(cst_pkg::QUOTE_CHAR);
                    for (int i = 0; i < len; i++) begin
                        case ($urandom_range(0, 7))
                            0: send_text("\"\"");
                            1: send_char(cfg_delim);
                            default: send_char(text_char());
                        endcase
                    end
                    send_char(cst_pkg::QUOTE_CHAR);
                end
                default: begin
                    for (int i = 0; i < len; i++) begin
                        send_char(text_char());
                        // now and then a run long enough that it may overflow the hold store
                        if ($urandom_range(0, 40) == 0) send_blanks($urandom_range(60, 70));
                    end
                end
            endcase
            if ($urandom_range(0, 3) == 0) send_blanks($urandom_range(1, 3));
        end
        ending = $urandom_range(0, 9);
        if (ending == 9) begin
            send_item(KIND_FLUSH, 8'($urandom_range(0, 255)));
        end else begin
            if (ending >= 7) send_char(cst_pkg::CR_CHAR);
            send_char(cst_pkg::LF_CHAR);
        end
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 3))
            0: send_item(KIND_FLUSH, 8'($urandom_range(0, 255)));
            1: send_char(cst_pkg::QUOTE_CHAR);
            default: send_char(8'($urandom_range(0, 255)));
        endcase
    endtask

    // ---------------- tests ----------------

    task automatic test_reset_values();
        read_check(cst_pkg::REG_DELIMITER, {24'd0, cst_pkg::DELIMITER_RESET}, 32'hFF);
        read_check(cst_pkg::REG_TRIM, {31'd0, cst_pkg::TRIM_RESET}, 32'h1);
    endtask

    task automatic test_basic_parsing();
        send_char(cst_pkg::SPACE_CHAR);     // leading blank before the record starts
        send_char("a");
        send_char(cst_pkg::SPACE_CHAR);
        send_char(cst_pkg::TAB_CHAR);
        send_char("b");                     // releases the held pair
        send_char(cst_pkg::SPACE_CHAR);     // trailing blank, dropped at field end
        send_char(",");
        send_text("\"x\"\"y\"");           // doubled quote inside quotes
        send_char(cst_pkg::CR_CHAR);
        send_char(cst_pkg::LF_CHAR);        // pending quote closes at end of line
        send_char(cst_pkg::LF_CHAR);        // empty line
        send_char(cst_pkg::SPACE_CHAR);
        send_char(cst_pkg::LF_CHAR);        // blank-only line under trim
        send_char(8'h00);
        send_char(8'hFF);
        send_item(KIND_FLUSH, 8'hA5);
        send_item(KIND_FLUSH, 8'h5A);       // flush with no open record
        send_text("\",\"z");                // delimiter inside quotes, close on plain byte
        send_char(cst_pkg::LF_CHAR);
        settle();
    endtask

    task automatic test_special_delimiters();
        set_config(cst_pkg::QUOTE_CHAR, 1'b0);
        send_text("\"a\"b");
        send_char(cst_pkg::LF_CHAR);
        set_config(cst_pkg::LF_CHAR, 1'b1);
        send_text("a");
        send_char(cst_pkg::LF_CHAR);
        set_config(cst_pkg::CR_CHAR, 1'b1);
        send_text("a");
        send_char(cst_pkg::CR_CHAR);
        send_text("b");
        send_char(cst_pkg::LF_CHAR);
        set_config(cst_pkg::SPACE_CHAR, 1'b1);
        send_text(" a  b");
        send_char(cst_pkg::LF_CHAR);
        set_config(cst_pkg::SPACE_CHAR, 1'b0);
        send_text(" a");
        send_char(cst_pkg::LF_CHAR);
        settle();
    endtask

    task automatic test_hold_store();
        set_config(",", 1'b1);
        send_char("a");
        send_blanks(70);
        send_char("b");
        send_char(cst_pkg::LF_CHAR);
        send_char("c");
        send_blanks(5);
        send_char(",");
        send_char("d");
        send_blanks(3);
        send_char(cst_pkg::LF_CHAR);
        // switch trim off with blanks still held
        send_char("e");
        send_blanks(3);
        settle();
        write_reg(cst_pkg::REG_TRIM, 32'd0);
        send_char("f");
        send_char(cst_pkg::LF_CHAR);
        settle();
    endtask

    task automatic test_wide_record();
        set_config(",", 1'b0);
        for (int i = 0; i < WIDE_FIELDS; i++) send_char(",");
        send_char("q");
        send_char(cst_pkg::LF_CHAR);
        settle();
    endtask

    task automatic test_backpressure();
        set_config(cst_pkg::DELIMITER_RESET, cst_pkg::TRIM_RESET);
        hold_off_req = 1'b1;
        for (int i = 0; i < 40; i++) send_char((i % 7 == 6) ? cfg_delim : text_char());
        send_char(cst_pkg::LF_CHAR);
        settle();
    endtask

    task automatic run_random_phase(logic [7:0] delim, logic trim);
        int start;
        set_config(delim, trim);
        start = items_sent;
        while (items_sent - start < PHASE_ITEMS) begin
            if ($urandom_range(0, 9) == 0) send_noise();
            else send_random_record();
        end
    endtask

    task automatic test_random_traffic();
        run_random_phase(8'h00, 1'b1);
        run_random_phase(8'hFF, 1'b0);
        run_random_phase(",", 1'b0);
        run_random_phase(cst_pkg::QUOTE_CHAR, 1'b1);
        run_random_phase(cst_pkg::SPACE_CHAR, 1'b1);
        run_random_phase(cst_pkg::TAB_CHAR, 1'b0);
        run_random_phase(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        run_random_phase(cst_pkg::DELIMITER_RESET, cst_pkg::TRIM_RESET);
        settle();
    endtask

    initial begin : run_tests
        s_valid     <= 1'b0;
        s_kind      <= KIND_DATA;
        s_data_byte <= 8'd0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        apply_reset();
        test_reset_values();
        test_basic_parsing();
        test_special_delimiters();
        test_hold_store();
        test_wide_record();
        test_backpressure();
        test_random_traffic();
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
